/* sv/pcmm_pkg.sv */
// pcmm_pkg: shared types, codes and constants of the pcm sample mixer
// holds the pitch step table built at elaboration; no dependencies
package pcmm_pkg;

   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_TUNE  = 3'd3,
      OP_QUERY = 3'd4,
      OP_MIX   = 3'd5
   } opcode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_START,
      S_VCHK,
      S_PROD,
      S_RECIP,
      S_ACCUM,
      S_DONE
   } state_type;

   typedef enum logic {
      MUL_LEVEL,
      MUL_RECIP
   } mul_mode_type;

   typedef struct packed {
      logic         en;
      mul_mode_type mode;
   } mul_ctrl_type;

   localparam int POS_W  = 19;
   localparam int FRAC_W = 16;
   localparam int STEP_W = 19;
   localparam int LVL_W  = 7;
   localparam int TICK_W = 31;
   localparam logic [POS_W-1:0] POS_MAX = 19'h7ffff;
   // sample memory size, a power of two so addresses wrap on the low bits
   localparam int SAMPLE_MEM_BYTES = 262144;
   localparam int MEM_AW = 18;
   // ceil(2^22 / 127): exact floor(y / 127) for y below 33554
   localparam logic [16:0] RECIP_127 = 17'd33027;
   localparam int RECIP_SHIFT = 22;
   localparam logic signed [17:0] SAT_HI = 18'sd32767;
   localparam logic signed [17:0] SAT_LO = -18'sd32768;

   typedef logic [255:0][STEP_W-1:0] pitch_rom_type;

   // entry p = floor(2^(17 + (p mod 64)/64)) >> (3 - p/64), found bit by bit with exact powers
   function automatic pitch_rom_type build_pitch_rom();
      pitch_rom_type rom;
      logic [17:0] base [64];
      logic [17:0] t;
      logic [17:0] c;
      logic [1215:0] w;
      logic [1215:0] lim;
      for (int k = 0; k < 64; k++) begin
         t = 18'h20000;
         for (int b = 16; b >= 0; b--) begin
            c = t | (18'd1 << b);
            w = 1216'(c);
            for (int i = 0; i < 6; i++) begin
               w = w * w;
            end
            lim = 1216'd1 << (1088 + k);
            if (w <= lim) begin
               t = c;
            end
         end
         base[k] = t;
      end
      for (int p = 0; p < 256; p++) begin
         rom[p] = STEP_W'(base[p % 64] >> (3 - (p / 64)));
      end
      return rom;
   endfunction

   localparam pitch_rom_type PITCH_STEP_ROM = build_pitch_rom();

endpackage

/* sv/multichannel_pcm_sample_mixer_core.sv */
// multichannel_pcm_sample_mixer_core: voice file, sequencer and result registers
// uses pcmm_pkg, pcmm_sample_mem and pcmm_mul_unit
// a write, stop, retune or query passes through the exec and done states; a start also scans every voice;
// a mix frame checks each voice and runs each voice that plays through the one shared multiplier
// one transaction at a time: busy stays high until the result strobe is issued
// synchronous reset idles all voices and clears their registers; sample memory is not cleared
module multichannel_pcm_sample_mixer_core import pcmm_pkg::*; #(
   parameter int VOICES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic [17:0]        req_address,
   input  logic [7:0]         req_sample_byte,
   input  logic [17:0]        req_length,
   input  logic [6:0]         req_volume,
   input  logic signed [8:0]  req_separation,
   input  logic [7:0]         req_pitch,
   input  logic [3:0]         req_voice,
   input  logic [30:0]        req_game_tick,
   output logic               rsp_valid,
   output logic [2:0]         rsp_handle,
   output logic               rsp_playing,
   output logic signed [15:0] rsp_left_out,
   output logic signed [15:0] rsp_right_out
);

   localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

   state_type state_ff, state_in;

   logic [2:0]        op_ff;
   logic [17:0]       addr_ff;
   logic [7:0]        byte_ff;
   logic [17:0]       len_ff;
   logic [6:0]        vol_ff;
   logic signed [8:0] sep_ff;
   logic [7:0]        pitch_ff;
   logic [3:0]        vsel_ff;
   logic [30:0]       gtick_ff;

   logic              active_ff [VOICES];
   logic [POS_W-1:0]  pos_ff    [VOICES];
   logic [POS_W-1:0]  end_ff    [VOICES];
   logic [STEP_W-1:0] step_ff   [VOICES];
   logic [FRAC_W-1:0] frac_ff   [VOICES];
   logic [LVL_W-1:0]  lvl_l_ff  [VOICES];
   logic [LVL_W-1:0]  lvl_r_ff  [VOICES];
   logic [TICK_W-1:0] tick_ff   [VOICES];

   logic [VW-1:0]     vidx_ff;
   logic [VW-1:0]     best_ff;
   logic [TICK_W:0]   best_tick_ff;
   logic              idle_found_ff;
   logic              side_ff;
   logic signed [15:0] p_ff;
   logic signed [15:0] acc_l_ff;
   logic signed [15:0] acc_r_ff;
   logic [2:0]        handle_ff;
   logic              playing_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic accept;
   logic [5:0] vsel_ext;
   logic vsel_ok;
   logic last_voice;
   logic cur_active;
   logic pos_done;

   // separation levels
   logic [8:0]  sep_mag;
   logic [15:0] att_x;
   logic [15:0] att_d;
   logic [7:0]  att_lvl;
   logic [LVL_W-1:0] new_l;
   logic [LVL_W-1:0] new_r;

   // position advance
   logic [19:0] frac_sum;
   logic [19:0] new_pos;
   logic [POS_W-1:0] adv_pos;
   logic [18:0] end_sum;

   // memory addressing
   logic [MEM_AW-1:0] mem_waddr;
   logic [MEM_AW-1:0] mem_raddr;
   logic          mem_we;
   logic          mem_re;
   logic [7:0]    mem_rdata;

   mul_ctrl_type       mul_ctrl;
   logic signed [31:0] prod;
   logic [15:0]        y_mag;
   logic [LVL_W-1:0]   mul_level;

   // contribution and saturation
   logic [16:0]        mag;
   logic signed [17:0] contrib;
   logic signed [17:0] acc_sel;
   logic signed [17:0] acc_sum;
   logic signed [15:0] acc_sat;
   logic [5:0]         best_ext;

   assign accept   = start && !busy;
   assign busy     = (state_ff != S_IDLE);
   assign vsel_ext = 6'(vsel_ff);
   assign vsel_ok  = (vsel_ext < 6'(VOICES));
   assign last_voice = (vidx_ff == VW'(VOICES - 1));
   assign cur_active = active_ff[vidx_ff];
   assign pos_done   = (pos_ff[vidx_ff] >= end_ff[vidx_ff]);

   always_comb begin
      sep_mag = sep_ff[8] ? 9'(-sep_ff) : 9'(sep_ff);
      att_x   = 16'(vol_ff) * 16'(sep_mag);
      // floor(x / 255) for x below 65280
      att_d   = (att_x + (att_x >> 8) + 16'd1) >> 8;
      att_lvl = 8'(vol_ff) - att_d[7:0];
      if (att_lvl[7]) begin
         att_lvl = '0;
      end
      new_l = vol_ff;
      new_r = vol_ff;
      if (sep_ff < 0) begin
         new_l = att_lvl[LVL_W-1:0];
      end else if (sep_ff > 0) begin
         new_r = att_lvl[LVL_W-1:0];
      end
   end

   always_comb begin
      frac_sum = 20'(frac_ff[vidx_ff]) + 20'(step_ff[vidx_ff]);
      new_pos  = 20'(pos_ff[vidx_ff]) + 20'(frac_sum[19:16]);
      adv_pos  = new_pos[19] ? POS_MAX : new_pos[POS_W-1:0];
      end_sum  = 19'(addr_ff) + 19'(len_ff);
   end

   // addresses wrap on the low bits of the memory size
   always_comb begin
      mem_waddr = addr_ff[MEM_AW-1:0];
      mem_raddr = pos_ff[vidx_ff][MEM_AW-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (op_ff == OP_START) begin
               state_in = S_SCAN;
            end else if (op_ff == OP_MIX) begin
               state_in = S_VCHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (last_voice) begin
               state_in = S_START;
            end
         end
         S_START: state_in = S_DONE;
         S_VCHK: begin
            if (cur_active && !pos_done) begin
               state_in = S_PROD;
            end else if (last_voice) begin
               state_in = S_DONE;
            end
         end
         S_PROD:  state_in = S_RECIP;
         S_RECIP: state_in = S_ACCUM;
         S_ACCUM: begin
            if (!side_ff) begin
               state_in = S_PROD;
            end else if (last_voice) begin
               state_in = S_DONE;
            end else begin
               state_in = S_VCHK;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mul_ctrl.en   = 1'b0;
      mul_ctrl.mode = MUL_LEVEL;
      rsp_valid_in  = 1'b0;
      unique case (state_ff)
         S_EXEC: mem_we = (op_ff == OP_WRITE);
         S_VCHK: mem_re = cur_active && !pos_done;
         S_PROD: begin
            mul_ctrl.en   = 1'b1;
            mul_ctrl.mode = MUL_LEVEL;
         end
         S_RECIP: begin
            mul_ctrl.en   = 1'b1;
            mul_ctrl.mode = MUL_RECIP;
         end
         S_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   pcmm_sample_mem #(
      .SAMPLE_MEM_BYTES(SAMPLE_MEM_BYTES),
      .AW(MEM_AW)
   ) u_mem (
      .clock(clock),
      .we(mem_we),
      .waddr(mem_waddr),
      .wdata(byte_ff),
      .re(mem_re),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   assign mul_level = side_ff ? lvl_r_ff[vidx_ff] : lvl_l_ff[vidx_ff];
   // y = 2|p|; the product from the level step is still in prod here
   assign y_mag = prod[15] ? 16'(-(prod[15:0] <<< 1)) : 16'(prod[15:0] << 1);

   pcmm_mul_unit u_mul (
      .clock(clock),
      .ctrl(mul_ctrl),
      .level(mul_level),
      .sample(mem_rdata),
      .y_mag(y_mag),
      .prod(prod)
   );

   // trunc(p*256/127) = sign(p) * (2|p| + floor(2|p|/127))
   always_comb begin
      mag     = (p_ff[15] ? 17'(-p_ff) : 17'(p_ff)) << 1;
      mag     = mag + 17'(prod >>> RECIP_SHIFT);
      contrib = p_ff[15] ? -signed'(18'(mag)) : signed'(18'(mag));
      acc_sel = side_ff ? 18'(acc_r_ff) : 18'(acc_l_ff);
      acc_sum = acc_sel + contrib;
      if (acc_sum > SAT_HI) begin
         acc_sat = SAT_HI[15:0];
      end else if (acc_sum < SAT_LO) begin
         acc_sat = SAT_LO[15:0];
      end else begin
         acc_sat = acc_sum[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         addr_ff  <= req_address;
         byte_ff  <= req_sample_byte;
         len_ff   <= req_length;
         vol_ff   <= req_volume;
         sep_ff   <= req_separation;
         pitch_ff <= req_pitch;
         vsel_ff  <= req_voice;
         gtick_ff <= req_game_tick;
      end
   end

   assign best_ext = 6'(best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vidx_ff       <= '0;
         best_ff       <= '0;
         best_tick_ff  <= '0;
         idle_found_ff <= 1'b0;
         side_ff       <= 1'b0;
         p_ff          <= '0;
         acc_l_ff      <= '0;
         acc_r_ff      <= '0;
         handle_ff     <= '0;
         playing_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  handle_ff  <= '0;
                  playing_ff <= 1'b0;
                  acc_l_ff   <= '0;
                  acc_r_ff   <= '0;
               end
            end
            S_EXEC: begin
               vidx_ff       <= (op_ff == OP_START || op_ff == OP_MIX) ? '0 : vsel_ext[VW-1:0];
               best_ff       <= '0;
               best_tick_ff  <= {1'b1, {TICK_W{1'b0}}};
               idle_found_ff <= 1'b0;
               side_ff       <= 1'b0;
               if (op_ff == OP_QUERY) begin
                  playing_ff <= vsel_ok && active_ff[vsel_ext[VW-1:0]];
               end
            end
            S_SCAN: begin
               if (!idle_found_ff) begin
                  if (!cur_active) begin
                     best_ff       <= vidx_ff;
                     idle_found_ff <= 1'b1;
                  end else if ({1'b0, tick_ff[vidx_ff]} < best_tick_ff) begin
                     best_ff      <= vidx_ff;
                     best_tick_ff <= {1'b0, tick_ff[vidx_ff]};
                  end
               end
               if (!last_voice) begin
                  vidx_ff <= vidx_ff + 1'b1;
               end
            end
            S_START: handle_ff <= best_ext[2:0];
            S_VCHK: begin
               side_ff <= 1'b0;
               if (!(cur_active && !pos_done) && !last_voice) begin
                  vidx_ff <= vidx_ff + 1'b1;
               end
            end
            S_RECIP: p_ff <= prod[15:0];
            S_ACCUM: begin
               if (side_ff) begin
                  acc_r_ff <= acc_sat;
                  if (!last_voice) begin
                     vidx_ff <= vidx_ff + 1'b1;
                  end
               end else begin
                  acc_l_ff <= acc_sat;
               end
               side_ff <= !side_ff;
            end
            default: ;
         endcase
      end
   end

   // voice file
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICES; v++) begin
            active_ff[v] <= 1'b0;
            pos_ff[v]    <= '0;
            end_ff[v]    <= '0;
            step_ff[v]   <= '0;
            frac_ff[v]   <= '0;
            lvl_l_ff[v]  <= '0;
            lvl_r_ff[v]  <= '0;
            tick_ff[v]   <= '0;
         end
      end else begin
         unique case (state_ff)
            S_EXEC: begin
               if (op_ff == OP_STOP && vsel_ok) begin
                  active_ff[vsel_ext[VW-1:0]] <= 1'b0;
               end
               if (op_ff == OP_TUNE && vsel_ok && active_ff[vsel_ext[VW-1:0]]) begin
                  lvl_l_ff[vsel_ext[VW-1:0]] <= new_l;
                  lvl_r_ff[vsel_ext[VW-1:0]] <= new_r;
                  step_ff[vsel_ext[VW-1:0]]  <= PITCH_STEP_ROM[pitch_ff];
               end
            end
            S_START: begin
               pos_ff[best_ff]    <= POS_W'(addr_ff);
               end_ff[best_ff]    <= end_sum;
               frac_ff[best_ff]   <= '0;
               lvl_l_ff[best_ff]  <= new_l;
               lvl_r_ff[best_ff]  <= new_r;
               step_ff[best_ff]   <= PITCH_STEP_ROM[pitch_ff];
               active_ff[best_ff] <= 1'b1;
               tick_ff[best_ff]   <= gtick_ff;
            end
            S_VCHK: begin
               if (cur_active) begin
                  if (pos_done) begin
                     active_ff[vidx_ff] <= 1'b0;
                  end else begin
                     frac_ff[vidx_ff] <= frac_sum[15:0];
                     if (frac_sum[19:16] != 4'd0) begin
                        pos_ff[vidx_ff] <= adv_pos;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_handle    = handle_ff;
   assign rsp_playing   = playing_ff;
   assign rsp_left_out  = acc_l_ff;
   assign rsp_right_out = acc_r_ff;

endmodule

/* sv/pcmm_sample_mem.sv */
// pcmm_sample_mem: byte-wide sample memory, one write and one registered read
// depends on nothing but its parameters
module pcmm_sample_mem #(
   parameter int SAMPLE_MEM_BYTES = 262144,
   parameter int AW = 18
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [7:0]    wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [7:0]    rdata
);

   logic [7:0] mem_ff [SAMPLE_MEM_BYTES];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/pcmm_mul_unit.sv */
// pcmm_mul_unit: shared signed multiplier with registered product
// uses pcmm_pkg for the control struct and the reciprocal constant
module pcmm_mul_unit import pcmm_pkg::*; (
   input  logic               clock,
   input  mul_ctrl_type       ctrl,
   input  logic [LVL_W-1:0]   level,
   input  logic [7:0]         sample,
   input  logic [15:0]        y_mag,
   output logic signed [31:0] prod
);

   logic signed [16:0] a;
   logic signed [16:0] b;
   logic signed [33:0] full;
   logic signed [31:0] prod_ff;

   always_comb begin
      unique case (ctrl.mode)
         MUL_LEVEL: begin
            a = signed'(17'(level));
            b = signed'(17'(sample)) - 17'sd128;
         end
         MUL_RECIP: begin
            a = signed'(17'(y_mag));
            b = signed'(RECIP_127);
         end
         default: begin
            a = '0;
            b = '0;
         end
      endcase
      full = a * b;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en) begin
         prod_ff <= full[31:0];
      end
   end

   assign prod = prod_ff;

endmodule
